// File: rtl/core/xsp_pkg.sv
// ----------------------------------------------------------------------------
// xsp_pkg
// Shared constants, operation codes and the controller-to-datapath command
// type for the seeded xorshift128+ generator.
// ----------------------------------------------------------------------------
package xsp_pkg;

   localparam int unsigned WORD_W     = 64;
   localparam int unsigned HALF_W     = 32;
   localparam int unsigned WARM_CNT_W = 8;   // holds any warm-up count 0..255
   localparam int unsigned WARMUP_ROUNDS = 32;

   localparam logic [WORD_W-1:0] GEN_A_RESET  = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] GEN_B_RESET  = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_ONE  = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_TWO  = 64'h94D049BB133111EB;

   // request action codes
   localparam logic ACT_DRAW = 1'b0;
   localparam logic ACT_SEED = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_DRAW      = 4'd1;  // advance and capture result
   localparam logic [3:0] OP_WARM      = 4'd2;  // advance, drop result
   localparam logic [3:0] OP_SEED      = 4'd3;  // load splitmix walker
   localparam logic [3:0] OP_MIX_START = 4'd4;  // first xor-shift, step walker
   localparam logic [3:0] OP_MUL       = 4'd5;  // one 32x32 partial product
   localparam logic [3:0] OP_ACC       = 4'd6;  // fold partial product in
   localparam logic [3:0] OP_MIX_MID   = 4'd7;  // second xor-shift
   localparam logic [3:0] OP_STORE     = 4'd8;  // final xor-shift into a word

   // partial product selection for a 64x64 mod 2^64 multiply
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] step;
      logic       mul_sel;  // 0: first mix constant, 1: second
      logic       word;     // 0: gen_a, 1: gen_b
   } cmd_type;

endpackage

// File: rtl/core/xsp_if.sv
// ----------------------------------------------------------------------------
// xsp_if
// Valid/ready channel interfaces for generator requests and responses.
// ----------------------------------------------------------------------------
interface xsp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] seed;

   modport source (output valid, output action, output seed, input ready);
   modport sink   (input valid, input action, input seed, output ready);
endinterface

interface xsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

// File: rtl/core/xsp_datapath.sv
// ----------------------------------------------------------------------------
// xsp_datapath
// Generator state words, xorshift128+ advance, splitmix64 mixer
// built around a shared 32x32 multiplier, and the response data register.
// ----------------------------------------------------------------------------
module xsp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  xsp_pkg::cmd_type        cmd,
   input  logic [63:0]             seed,
   output logic [63:0]             random_value
);
   import xsp_pkg::*;

   logic [WORD_W-1:0] gen_a_ff, gen_a_in;
   logic [WORD_W-1:0] gen_b_ff, gen_b_in;
   logic [WORD_W-1:0] walker_ff, walker_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] rnd_ff, rnd_in;

   logic [WORD_W-1:0] t0, t1, t2, adv_b, adv_sum;
   logic [WORD_W-1:0] mix_const, mix_out;
   logic [HALF_W-1:0] z_piece, c_piece;

   // xorshift128+ advance
   always_comb begin
      t0      = gen_a_ff ^ (gen_a_ff << 23);
      t1      = t0 ^ (t0 >> 17);
      t2      = t1 ^ gen_b_ff ^ (gen_b_ff >> 26);
      adv_b   = t2;
      adv_sum = t2 + gen_b_ff;
   end

   // partial product operand selection
   always_comb begin
      mix_const = cmd.mul_sel ? MIX_MUL_TWO : MIX_MUL_ONE;
      z_piece   = (cmd.step == STEP_HL) ? z_ff[WORD_W-1:HALF_W] : z_ff[HALF_W-1:0];
      c_piece   = (cmd.step == STEP_LH) ? mix_const[WORD_W-1:HALF_W]
                                        : mix_const[HALF_W-1:0];
      mix_out   = acc_ff ^ (acc_ff >> 31);
   end

   always_comb begin
      gen_a_in  = gen_a_ff;
      gen_b_in  = gen_b_ff;
      walker_in = walker_ff;
      z_in      = z_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      rnd_in    = rnd_ff;
      unique case (cmd.op)
         OP_DRAW: begin
            gen_a_in = gen_b_ff;
            gen_b_in = adv_b;
            rnd_in   = adv_sum;
         end
         OP_WARM: begin
            gen_a_in = gen_b_ff;
            gen_b_in = adv_b;
         end
         OP_SEED: begin
            walker_in = seed;
         end
         OP_MIX_START: begin
            z_in      = walker_ff ^ (walker_ff >> 30);
            walker_in = walker_ff + GOLDEN_GAMMA;
         end
         OP_MUL: begin
            prod_in = {{HALF_W{1'b0}}, z_piece} * {{HALF_W{1'b0}}, c_piece};
         end
         OP_ACC: begin
            // low product seeds the sum, cross products add in the top half
            if (cmd.step == STEP_LL) begin
               acc_in = prod_ff;
            end else begin
               acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            end
         end
         OP_MIX_MID: begin
            z_in = acc_ff ^ (acc_ff >> 27);
         end
         OP_STORE: begin
            if (cmd.word) begin
               gen_b_in = mix_out;
            end else begin
               gen_a_in = mix_out;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff <= GEN_A_RESET;
         gen_b_ff <= GEN_B_RESET;
      end else begin
         gen_a_ff <= gen_a_in;
         gen_b_ff <= gen_b_in;
      end
   end

   always_ff @(posedge clock) begin
      walker_ff <= walker_in;
      z_ff      <= z_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      rnd_ff    <= rnd_in;
   end

   assign random_value = rnd_ff;

endmodule

// File: rtl/core/xsp_ctrl.sv
// ----------------------------------------------------------------------------
// xsp_ctrl
// Sequencer for draws, the splitmix64 seeding passes and the warm-up rounds;
// owns the request ready and the response valid flag.
// ----------------------------------------------------------------------------
module xsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xsp_pkg::cmd_type  cmd
);
   import xsp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_ACC   = 3'd3;
   localparam logic [2:0] S_MID   = 3'd4;
   localparam logic [2:0] S_STORE = 3'd5;
   localparam logic [2:0] S_WARM  = 3'd6;

   localparam logic [WARM_CNT_W-1:0] WARM_LAST = WARM_CNT_W'(WARMUP_ROUNDS - 1);

   logic [2:0]            state_ff, state_in;
   logic [1:0]            step_ff, step_in;
   logic                  phase_ff, phase_in;
   logic                  word_ff, word_in;
   logic [WARM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '{op: OP_NONE, step: step_ff, mul_sel: phase_ff, word: word_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACT_DRAW)) begin
               cmd.op       = OP_DRAW;
               rsp_valid_in = 1'b1;
            end else if (accept) begin
               cmd.op   = OP_SEED;
               word_in  = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.op   = OP_MIX_START;
            phase_in = 1'b0;
            step_in  = STEP_LL;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (step_ff == STEP_HL) begin
               state_in = phase_ff ? S_STORE : S_MID;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_MID: begin
            cmd.op   = OP_MIX_MID;
            phase_in = 1'b1;
            step_in  = STEP_LL;
            state_in = S_MUL;
         end
         S_STORE: begin
            cmd.op = OP_STORE;
            if (!word_ff) begin
               word_in  = 1'b1;
               state_in = S_START;
            end else if (WARMUP_ROUNDS == 0) begin
               state_in = S_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = S_WARM;
            end
         end
         S_WARM: begin
            cmd.op = OP_WARM;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WARM_LAST) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_LL;
         phase_ff     <= 1'b0;
         word_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         word_ff      <= word_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/xorshift128p_prng_with_seeding_core.sv
// ----------------------------------------------------------------------------
// xorshift128p_prng_with_seeding_core
// Seeded xorshift128+ pseudo-random generator.
// ----------------------------------------------------------------------------
// Usage:
//   req carries action and seed. action = draw returns one 64-bit number on
//   rsp; action = seed reloads both state words from two splitmix64 outputs
//   of seed, runs 32 warm-up rounds and returns nothing.
//   A draw: the state advances at the accepting edge and the number
//   appears on rsp in the next cycle. req_ready is high while the block is
//   idle and the response register is empty or being taken, so draws run
//   one per cycle. A seed transaction keeps the block busy: per state word
//   it does the first xor-shift, two 64-bit multiplies of three 32x32
//   partial products (multiply then accumulate each), one middle xor-shift
//   and one store, followed by 32 warm-up rounds. The shared 32x32
//   multiplier is why each multiply is split into partial products.
//   Reset (synchronous) loads the default state words and empties rsp.
//   While rsp is stalled the number holds and req_ready drops, so no draw
//   is lost.
// ----------------------------------------------------------------------------
module xorshift128p_prng_with_seeding_core (
   input  logic       clock,
   input  logic       reset,
   xsp_req_if.sink    req,
   xsp_rsp_if.source  rsp
);
   import xsp_pkg::*;

   cmd_type cmd;

   xsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd)
   );

   xsp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .seed         (req.seed),
      .random_value (rsp.random_value)
   );

endmodule

// File: rtl/core/xsp_checker.sv
// ----------------------------------------------------------------------------
// xsp_checker
// Port-level checks for the generator core, attached by bind.
// ----------------------------------------------------------------------------
module xsp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_random_value
);
   import xsp_pkg::*;

   // a stalled response holds its number
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
      else $error("response changed while stalled");

   // a draw always yields a response in the next cycle
   a_draw_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_DRAW) |=> rsp_valid)
      else $error("draw produced no response");

   // a seed transaction yields no new response
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_SEED) |=> !$rose(rsp_valid))
      else $error("seed produced a response");

   // seeding keeps the block busy
   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_SEED) |=> !req_ready)
      else $error("request taken during seeding");

   // never accept while the response register is full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("ready with a stalled response");

endmodule

bind xorshift128p_prng_with_seeding_core xsp_checker u_xsp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_action       (req.action),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_random_value (rsp.random_value)
);
